[rtl/core/utf8_to_utf16_decoder_core_assert.svh]
// ---------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder assertion macros
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_DECODER_CORE_ASSERT_SVH
`define UTF8_TO_UTF16_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define U8U16_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8u16 same-cycle check failed");

// next-cycle implication
`define U8U16_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8u16 next-cycle check failed");

`endif

[rtl/core/u8u16_pkg.sv]
// ---------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the UTF-8 to UTF-16 decoder.
// ---------------------------------------------------------------------------
package u8u16_pkg;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_BYTE  = 2'd1,
        ST_TRUNCATED = 2'd2,
        ST_BAD_POINT = 2'd3
    } status_t;

    localparam logic [20:0] MAX_POINT  = 21'h10ffff;
    localparam logic [20:0] SURR_LO    = 21'h00d800;
    localparam logic [20:0] SURR_HI    = 21'h00dfff;
    localparam logic [20:0] MIN_LEN2   = 21'h000080;
    localparam logic [20:0] MIN_LEN3   = 21'h000800;
    localparam logic [20:0] MIN_LEN4   = 21'h010000;
    localparam logic [20:0] BMP_MAX    = 21'h00ffff;
    localparam logic [15:0] HIGH_BASE  = 16'hd800;
    localparam logic [15:0] LOW_BASE   = 16'hdc00;

    // one result request
    typedef struct packed {
        logic [15:0] unit_out;
        status_t     status;
        logic        run_last;
        logic        string_end;
    } result_t;

    // decoder state carried between bytes
    typedef struct packed {
        logic [20:0] partial_point;
        logic [1:0]  bytes_missing;
        logic [2:0]  sequence_length;
        logic        discarding;
    } dec_state_t;

    // results of one byte: count (0..2) and up to two results
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } step_out_t;

endpackage

[rtl/core/u8u16_step.sv]
// ---------------------------------------------------------------------------
// u8u16_step
// Per-byte decode: next state and up to two results from one byte.
// ---------------------------------------------------------------------------
module u8u16_step
(
    input  u8u16_pkg::dec_state_t cur,
    input  logic [7:0]            byte_in,
    input  logic                  string_last,
    output u8u16_pkg::dec_state_t nxt,
    output u8u16_pkg::step_out_t  res
);

    logic [20:0] pp_new;
    logic [1:0]  miss_new;
    logic [20:0] minimum;
    logic [20:0] cp_off;
    logic        lead_ok;
    logic [2:0]  lead_len;
    logic [20:0] lead_pp;

    assign pp_new   = {cur.partial_point[14:0], byte_in[5:0]};
    assign miss_new = cur.bytes_missing - 2'd1;
    assign cp_off   = pp_new - u8u16_pkg::MIN_LEN4;

    always_comb
    begin
        lead_ok  = 1'b1;
        lead_len = 3'd0;
        lead_pp  = '0;
        if (byte_in[7:5] == 3'b110)
        begin
            lead_len = 3'd2;
            lead_pp  = {16'd0, byte_in[4:0]};
        end
        else if (byte_in[7:4] == 4'b1110)
        begin
            lead_len = 3'd3;
            lead_pp  = {17'd0, byte_in[3:0]};
        end
        else if (byte_in[7:3] == 5'b11110)
        begin
            lead_len = 3'd4;
            lead_pp  = {18'd0, byte_in[2:0]};
        end
        else
        begin
            lead_ok = 1'b0;
        end
    end

    always_comb
    begin
        unique case (cur.sequence_length)
            3'd2:    minimum = u8u16_pkg::MIN_LEN2;
            3'd3:    minimum = u8u16_pkg::MIN_LEN3;
            default: minimum = u8u16_pkg::MIN_LEN4;
        endcase
    end

    always_comb
    begin
        nxt                = cur;
        res.count          = 2'd0;
        res.r0.unit_out    = '0;
        res.r0.status      = u8u16_pkg::ST_OK;
        res.r0.run_last    = 1'b1;
        res.r0.string_end  = string_last;
        res.r1.unit_out    = '0;
        res.r1.status      = u8u16_pkg::ST_OK;
        res.r1.run_last    = 1'b1;
        res.r1.string_end  = string_last;

        if (cur.discarding)
        begin
            if (string_last)
                nxt.discarding = 1'b0;
        end
        else if (cur.bytes_missing == 2'd0)
        begin
            if (!byte_in[7])
            begin
                res.count       = 2'd1;
                res.r0.unit_out = {8'd0, byte_in};
            end
            else if (!lead_ok || string_last)
            begin
                // bad lead, or a multi-byte lead as the final byte
                nxt.partial_point   = '0;
                nxt.bytes_missing   = '0;
                nxt.sequence_length = '0;
                nxt.discarding      = !string_last;
                res.count           = 2'd1;
                res.r0.status       = lead_ok ? u8u16_pkg::ST_TRUNCATED
                                              : u8u16_pkg::ST_BAD_BYTE;
            end
            else
            begin
                nxt.partial_point   = lead_pp;
                nxt.sequence_length = lead_len;
                nxt.bytes_missing   = lead_len[1:0] - 2'd1;
            end
        end
        else if ((string_last && cur.bytes_missing[1]) || byte_in[7:6] != 2'b10)
        begin
            nxt.partial_point   = '0;
            nxt.bytes_missing   = '0;
            nxt.sequence_length = '0;
            nxt.discarding      = !string_last;
            res.count           = 2'd1;
            res.r0.status       = (string_last && cur.bytes_missing[1])
                                  ? u8u16_pkg::ST_TRUNCATED : u8u16_pkg::ST_BAD_BYTE;
        end
        else if (miss_new != 2'd0)
        begin
            nxt.partial_point = pp_new;
            nxt.bytes_missing = miss_new;
        end
        else
        begin
            nxt.partial_point   = '0;
            nxt.bytes_missing   = '0;
            nxt.sequence_length = '0;
            res.count           = 2'd1;
            if (pp_new < minimum || pp_new > u8u16_pkg::MAX_POINT ||
                (pp_new >= u8u16_pkg::SURR_LO && pp_new <= u8u16_pkg::SURR_HI))
            begin
                nxt.discarding = !string_last;
                res.r0.status  = u8u16_pkg::ST_BAD_POINT;
            end
            else if (pp_new <= u8u16_pkg::BMP_MAX)
            begin
                res.r0.unit_out = pp_new[15:0];
            end
            else
            begin
                // surrogate pair, high unit first
                res.count         = 2'd2;
                res.r0.unit_out   = u8u16_pkg::HIGH_BASE + {6'd0, cp_off[19:10]};
                res.r0.run_last   = 1'b0;
                res.r1.unit_out   = u8u16_pkg::LOW_BASE + {6'd0, cp_off[9:0]};
            end
        end
    end

endmodule

[rtl/core/utf8_to_utf16_decoder_core.sv]
// ---------------------------------------------------------------------------
// utf8_to_utf16_decoder_core
// Streaming UTF-8 to UTF-16 transcoder, one byte per cycle unless stalled.
// ---------------------------------------------------------------------------
// Usage:
//   Slave side takes one UTF-8 byte per request (s_tdata), s_tlast marks the
//   final byte of a string. Master side gives one UTF-16 unit per request
//   (m_tdata) with status and a per-byte run marker in m_tuser; m_tlast
//   repeats the causing byte's string flag.
//   An accepted byte waits in the input register until the decode stage
//   advances and registers its results in the result slots. Throughput: one
//   byte per cycle while m_tready is high and each byte gives at most one
//   result; a code point above U+FFFF gives a surrogate pair, whose low unit
//   waits in the spare slot until the high unit is taken, and decode holds
//   its byte meanwhile. Bytes that finish no code point give no result.
//   Errors give one result with unit zero; the rest of that string is then
//   dropped up to and including its s_tlast byte.
//   Reset clears the decoder state and empties the input register and
//   both result slots. While a result waits with m_tready low, the slots
//   hold, decode stalls, and s_tready drops once the input register is full.
// ---------------------------------------------------------------------------
module utf8_to_utf16_decoder_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic        s_tlast,   // string_last

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] unit_out
    output logic [2:0]  m_tuser,   // [1:0] status, [2] run_last
    output logic        m_tlast    // string_end
);

    // input register
    logic                  in_valid_reg, in_valid_next;
    logic [7:0]            in_byte_reg;
    logic                  in_last_reg;

    // decoder state
    u8u16_pkg::dec_state_t state_reg, state_next;
    u8u16_pkg::step_out_t  step_res;

    // result slots: a drives the port, b holds the low surrogate
    u8u16_pkg::result_t    a_reg, a_next;
    u8u16_pkg::result_t    b_reg, b_next;
    logic                  a_valid_reg, a_valid_next;
    logic                  b_valid_reg, b_valid_next;

    logic                  pop;
    logic                  advance;

    u8u16_step u_step
    (
        .cur         (state_reg),
        .byte_in     (in_byte_reg),
        .string_last (in_last_reg),
        .nxt         (state_next),
        .res         (step_res)
    );

    assign pop      = a_valid_reg && m_tready;
    // decode moves on only if both slots will be free for its results
    assign advance  = in_valid_reg && !b_valid_reg && (!a_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = a_valid_reg;
    assign m_tdata  = a_reg.unit_out;
    assign m_tuser  = {a_reg.run_last, a_reg.status};
    assign m_tlast  = a_reg.string_end;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
            in_valid_next = s_tvalid;
    end

    always_comb
    begin
        a_next       = a_reg;
        b_next       = b_reg;
        a_valid_next = a_valid_reg;
        b_valid_next = b_valid_reg;
        if (advance)
        begin
            a_next       = step_res.r0;
            b_next       = step_res.r1;
            a_valid_next = step_res.count != 2'd0;
            b_valid_next = step_res.count == 2'd2;
        end
        else if (pop)
        begin
            if (b_valid_reg)
            begin
                a_next       = b_reg;
                b_valid_next = 1'b0;
            end
            else
            begin
                a_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            state_reg    <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            a_valid_reg  <= a_valid_next;
            b_valid_reg  <= b_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        a_reg <= a_next;
        b_reg <= b_next;
    end

`include "utf8_to_utf16_decoder_core_assert.svh"

    `U8U16_ASSERT_IMP(a_spare_needs_head, b_valid_reg, a_valid_reg)
    `U8U16_ASSERT_IMP(a_pair_order, b_valid_reg, !a_reg.run_last && b_reg.run_last)
    `U8U16_ASSERT_IMP(a_error_zero_unit, a_valid_reg && a_reg.status != u8u16_pkg::ST_OK,
                      a_reg.unit_out == 16'd0 && a_reg.run_last)
    `U8U16_ASSERT_IMP(a_stall_on_pair, b_valid_reg && in_valid_reg, !s_tready)
    `U8U16_ASSERT_NXT(a_hold_on_stall, m_tvalid && !m_tready, m_tvalid)

endmodule

[tb/utf8_to_utf16_decoder_core_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8_to_utf16_decoder_core_tb
// Self-checking bench for the streaming UTF-8 to UTF-16 decoder. A short
// table of hand-picked bytes comes first, then random strings, mostly
// well-formed with corruption mixed in. Every output request is checked
// against the local model or typed rows, with random gaps and stalls on both sides.
// ---------------------------------------------------------------------------
module utf8_to_utf16_decoder_core_tb;

    localparam int  HOLD_OFF_CYCLES = 300;  // long receiver stall, fills the pipe
    localparam int  DRAIN_CYCLES    = 20;   // two-stage latency plus spare slot
    localparam int  DIR_ROWS        = 25;

    // stimulus item: one byte and its end-of-string flag
    typedef struct packed {
        logic [7:0] b;
        logic       l;
    } stim_t;

    // directed row; typed rows carry their expected result by hand
    typedef struct packed {
        logic [7:0]           b;
        logic                 l;
        logic                 typed;
        logic [1:0]           n;
        logic [15:0]          unit;
        u8u16_pkg::status_t   st;
    } dir_row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] byte_in
    logic        s_tlast  = 1'b0;    // string_last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [15:0] unit_out
    logic [2:0]  m_tuser;            // [1:0] status, [2] run_last
    logic        m_tlast;            // string_end

    u8u16_pkg::result_t pending_units [$];  // expected output requests, oldest first
    stim_t       rand_stim [$];
    logic [7:0]  str_bytes [$];      // scratch for one random string
    int          mismatches    = 0;
    bit          hold_off_req  = 1'b0;
    bit          hold_off_done = 1'b0;
    bit          calm          = 1'b0;   // end of run: no idling on either side

    // decoder model state
    logic [20:0] acc_point = '0;
    logic [1:0]  need_cont = '0;
    logic [2:0]  seq_len   = '0;
    logic        dropping  = 1'b0;

    dir_row_t dir_rows [0:DIR_ROWS-1] = '{
        '{8'h00, 1'b0, 1'b1, 2'd1, 16'h0000, u8u16_pkg::ST_OK},         // smallest ASCII
        '{8'h7f, 1'b1, 1'b1, 2'd1, 16'h007f, u8u16_pkg::ST_OK},         // largest ASCII, end
        '{8'h80, 1'b1, 1'b1, 2'd1, 16'h0000, u8u16_pkg::ST_BAD_BYTE},   // continuation as lead
        '{8'hff, 1'b0, 1'b1, 2'd1, 16'h0000, u8u16_pkg::ST_BAD_BYTE},   // 0xF8..0xFF lead
        '{8'h41, 1'b1, 1'b1, 2'd0, 16'h0000, u8u16_pkg::ST_OK},         // dropped, ends discard
        '{8'hc0, 1'b0, 1'b1, 2'd0, 16'h0000, u8u16_pkg::ST_OK},
        '{8'h80, 1'b0, 1'b1, 2'd1, 16'h0000, u8u16_pkg::ST_BAD_POINT},  // overlong two-byte
        '{8'h55, 1'b1, 1'b1, 2'd0, 16'h0000, u8u16_pkg::ST_OK},
        '{8'he0, 1'b1, 1'b1, 2'd1, 16'h0000, u8u16_pkg::ST_TRUNCATED},  // lead as final byte
        '{8'he2, 1'b0, 1'b1, 2'd0, 16'h0000, u8u16_pkg::ST_OK},
        '{8'h82, 1'b1, 1'b1, 2'd1, 16'h0000, u8u16_pkg::ST_TRUNCATED},  // final, two missing
        '{8'hc2, 1'b0, 1'b1, 2'd0, 16'h0000, u8u16_pkg::ST_OK},
        '{8'h41, 1'b0, 1'b1, 2'd1, 16'h0000, u8u16_pkg::ST_BAD_BYTE},   // bad continuation
        '{8'h00, 1'b1, 1'b1, 2'd0, 16'h0000, u8u16_pkg::ST_OK},
        '{8'hed, 1'b0, 1'b1, 2'd0, 16'h0000, u8u16_pkg::ST_OK},
        '{8'ha0, 1'b0, 1'b1, 2'd0, 16'h0000, u8u16_pkg::ST_OK},
        '{8'h80, 1'b1, 1'b1, 2'd1, 16'h0000, u8u16_pkg::ST_BAD_POINT},  // surrogate U+D800
        '{8'hf4, 1'b0, 1'b0, 2'd0, 16'h0000, u8u16_pkg::ST_OK},         // U+10FFFF, pair
        '{8'h8f, 1'b0, 1'b0, 2'd0, 16'h0000, u8u16_pkg::ST_OK},
        '{8'hbf, 1'b0, 1'b0, 2'd0, 16'h0000, u8u16_pkg::ST_OK},
        '{8'hbf, 1'b1, 1'b0, 2'd0, 16'h0000, u8u16_pkg::ST_OK},         // final, one missing
        '{8'hf5, 1'b0, 1'b1, 2'd0, 16'h0000, u8u16_pkg::ST_OK},         // lead above U+10FFFF
        '{8'h80, 1'b0, 1'b1, 2'd0, 16'h0000, u8u16_pkg::ST_OK},
        '{8'h80, 1'b0, 1'b1, 2'd0, 16'h0000, u8u16_pkg::ST_OK},
        '{8'h80, 1'b1, 1'b1, 2'd1, 16'h0000, u8u16_pkg::ST_BAD_POINT}
    };

    utf8_to_utf16_decoder_core DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // append helpers for the queues
    function automatic void add_expect(input u8u16_pkg::result_t r);
        pending_units.insert(pending_units.size(), r);
    endfunction

    function automatic void add_str_byte(input logic [7:0] b);
        str_bytes.insert(str_bytes.size(), b);
    endfunction

    // error result: clears the sequence, drops the rest of the string
    function automatic int drop_string(input u8u16_pkg::status_t st, input logic fin,
                                       output u8u16_pkg::result_t r);
        acc_point = '0;
        need_cont = '0;
        seq_len   = '0;
        dropping  = ~fin;
        r = '{unit_out: 16'h0000, status: st, run_last: 1'b1, string_end: fin};
        return 1;
    endfunction

    // decoder model: one byte in, 0..2 output requests out
    function automatic int decode_utf8_byte(input logic [7:0] b, input logic fin,
                                            output u8u16_pkg::result_t r0,
                                            output u8u16_pkg::result_t r1);
        logic [20:0] cp;
        logic [20:0] min_pt;
        r0 = '0;
        r1 = '0;
        if (dropping)
        begin
            if (fin)
                dropping = 1'b0;
            return 0;
        end
        if (need_cont == 2'd0)
        begin
            if (b < 8'h80)
            begin
                r0 = '{unit_out: {8'h00, b}, status: u8u16_pkg::ST_OK,
                       run_last: 1'b1, string_end: fin};
                return 1;
            end
            if (b[7:5] == 3'b110)
            begin
                acc_point = {16'h0000, b[4:0]};
                seq_len   = 3'd2;
            end
            else if (b[7:4] == 4'b1110)
            begin
                acc_point = {17'h00000, b[3:0]};
                seq_len   = 3'd3;
            end
            else if (b[7:3] == 5'b11110)
            begin
                acc_point = {18'h00000, b[2:0]};
                seq_len   = 3'd4;
            end
            else
                return drop_string(u8u16_pkg::ST_BAD_BYTE, fin, r0);
            need_cont = 2'(seq_len - 3'd1);
            if (fin)
                return drop_string(u8u16_pkg::ST_TRUNCATED, fin, r0);
            return 0;
        end
        // final byte with two or more missing is truncation whatever it is
        if (fin && need_cont >= 2'd2)
            return drop_string(u8u16_pkg::ST_TRUNCATED, fin, r0);
        if (b[7:6] != 2'b10)
            return drop_string(u8u16_pkg::ST_BAD_BYTE, fin, r0);
        acc_point = {acc_point[14:0], b[5:0]};
        need_cont = need_cont - 2'd1;
        if (need_cont != 2'd0)
            return 0;
        cp     = acc_point;
        min_pt = (seq_len == 3'd2) ? u8u16_pkg::MIN_LEN2 :
                 (seq_len == 3'd3) ? u8u16_pkg::MIN_LEN3 : u8u16_pkg::MIN_LEN4;
        if (cp < min_pt || cp > u8u16_pkg::MAX_POINT ||
            (cp >= u8u16_pkg::SURR_LO && cp <= u8u16_pkg::SURR_HI))
            return drop_string(u8u16_pkg::ST_BAD_POINT, fin, r0);
        acc_point = '0;
        seq_len   = '0;
        if (cp <= u8u16_pkg::BMP_MAX)
        begin
            r0 = '{unit_out: cp[15:0], status: u8u16_pkg::ST_OK,
                   run_last: 1'b1, string_end: fin};
            return 1;
        end
        // surrogate pair, high unit first
        cp = cp - u8u16_pkg::MIN_LEN4;
        r0 = '{unit_out: u8u16_pkg::HIGH_BASE + {6'h00, cp[19:10]},
               status: u8u16_pkg::ST_OK, run_last: 1'b0, string_end: fin};
        r1 = '{unit_out: u8u16_pkg::LOW_BASE + {6'h00, cp[9:0]},
               status: u8u16_pkg::ST_OK, run_last: 1'b1, string_end: fin};
        return 2;
    endfunction

    task automatic predict_and_queue(input stim_t it);
        u8u16_pkg::result_t r0;
        u8u16_pkg::result_t r1;
        int                 n;
        n = decode_utf8_byte(it.b, it.l, r0, r1);
        if (n > 0)
            add_expect(r0);
        if (n > 1)
            add_expect(r1);
    endtask

    // encode cp with len bytes; lengths need not be minimal (overlong on purpose)
    task automatic append_point(input logic [20:0] cp, input int len);
        case (len)
            1:
            begin
                add_str_byte({1'b0, cp[6:0]});
            end
            2:
            begin
                add_str_byte({3'b110, cp[10:6]});
                add_str_byte({2'b10, cp[5:0]});
            end
            3:
            begin
                add_str_byte({4'b1110, cp[15:12]});
                add_str_byte({2'b10, cp[11:6]});
                add_str_byte({2'b10, cp[5:0]});
            end
            default:
            begin
                add_str_byte({5'b11110, cp[20:18]});
                add_str_byte({2'b10, cp[17:12]});
                add_str_byte({2'b10, cp[11:6]});
                add_str_byte({2'b10, cp[5:0]});
            end
        endcase
    endtask

    // random strings: mostly valid code points, some corrupted, some pure noise
    task automatic build_random_stimulus();
        int          len;
        int          mode;
        int          last_idx;
        logic [20:0] cp;
        while (rand_stim.size() < 1300)
        begin
            str_bytes.delete();
            if ($urandom_range(0, 11) == 0)
            begin
                repeat ($urandom_range(1, 6))
                    add_str_byte(8'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 5))
                begin
                    case ($urandom_range(0, 9))
                        3:       begin len = 2; cp = 21'($urandom_range(21'h80, 21'h7ff)); end
                        4, 5:    begin len = 3; cp = 21'($urandom_range(21'h800, 21'hffff)); end
                        6:       begin len = 4; cp = 21'($urandom_range(21'h10000, 21'h10ffff)); end
                        7:
                        begin
                            case ($urandom_range(0, 11))
                                0:       begin cp = 21'h000000; len = 1; end
                                1:       begin cp = 21'h00007f; len = 1; end
                                2:       begin cp = 21'h000080; len = 2; end
                                3:       begin cp = 21'h0007ff; len = 2; end
                                4:       begin cp = 21'h000800; len = 3; end
                                5:       begin cp = 21'h00ffff; len = 3; end
                                6:       begin cp = 21'h010000; len = 4; end
                                7:       begin cp = 21'h10ffff; len = 4; end
                                8:       begin cp = 21'h00d7ff; len = 3; end
                                9:       begin cp = 21'h00e000; len = 3; end
                                10:      begin cp = 21'h00dfff; len = 3; end
                                default: begin cp = 21'h110000; len = 4; end
                            endcase
                        end
                        8:
                        begin
                            // any payload at any length: overlong, surrogate, too large
                            len = $urandom_range(2, 4);
                            cp  = 21'($urandom);
                        end
                        default: begin len = 1; cp = 21'($urandom_range(0, 127)); end
                    endcase
                    append_point(cp, len);
                end
                mode = $urandom_range(0, 9);
                if (mode == 7)
                    str_bytes[$urandom_range(0, str_bytes.size() - 1)] = 8'($urandom);
                else if (mode == 8 && str_bytes.size() > 1)
                    repeat ($urandom_range(1, str_bytes.size() - 1))
                        void'(str_bytes.pop_back());
                else if (mode == 9)
                    str_bytes.insert($urandom_range(0, str_bytes.size()), 8'($urandom));
            end
            last_idx = str_bytes.size() - 1;
            foreach (str_bytes[i])
                rand_stim.insert(rand_stim.size(), '{b: str_bytes[i], l: (i == last_idx)});
        end
    endtask

    // offer one request, optionally after an idle burst; returns at the accept edge
    task automatic send_item(input stim_t it);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it.b;
        s_tlast  <= it.l;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // sender: directed table, then random strings
    initial
    begin
        stim_t              it;
        u8u16_pkg::result_t r0;
        u8u16_pkg::result_t r1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        build_random_stimulus();
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            it = '{b: dir_rows[i].b, l: dir_rows[i].l};
            send_item(it);
            if (dir_rows[i].typed)
            begin
                // model still steps so its state follows the stream
                void'(decode_utf8_byte(it.b, it.l, r0, r1));
                if (dir_rows[i].n != 2'd0)
                    add_expect('{unit_out: dir_rows[i].unit,
                                 status: dir_rows[i].st,
                                 run_last: 1'b1, string_end: it.l});
            end
            else
                predict_and_queue(it);
        end
        for (int i = 0; i < rand_stim.size(); i++)
        begin
            if (i == 300)
                hold_off_req = 1'b1;
            if (i == rand_stim.size() - 150)
                calm = 1'b1;
            send_item(rand_stim[i]);
            predict_and_queue(rand_stim[i]);
        end
        s_tvalid <= 1'b0;
        while (pending_units.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("** utf8_to_utf16_decoder_core: PASSED **");
        else
            $display("** utf8_to_utf16_decoder_core: FAILED **");
        $finish;
    end

    // receiver: random stall bursts plus one long hold-off to back up the input
    initial
    begin
        wait (rst_n === 1'b1);
        m_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_off_done)
            begin
                hold_off_done = 1'b1;
                m_tready <= 1'b0;
                for (int k = 0; k < HOLD_OFF_CYCLES; k++)
                    @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    // checker: every accepted output request against the oldest expectation
    always @(posedge clk)
    begin : check_results
        u8u16_pkg::result_t got;
        u8u16_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{unit_out: m_tdata, status: u8u16_pkg::status_t'(m_tuser[1:0]),
                    run_last: m_tuser[2], string_end: m_tlast};
            if (pending_units.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected request: unit %h status %0d run_last %b end %b",
                             got.unit_out, got.status, got.run_last, got.string_end);
            end
            else
            begin
                want = pending_units.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp unit %h st %0d rl %b end %b, ",
                                  "got unit %h st %0d rl %b end %b"},
                                 want.unit_out, want.status, want.run_last,
                                 want.string_end, got.unit_out, got.status,
                                 got.run_last, got.string_end);
                end
            end
        end
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("** utf8_to_utf16_decoder_core: FAILED **");
        $finish;
    end

endmodule
